FILE: src/nv2rgb_pkg.sv
package nv2rgb_pkg;

	// configuration register widths and indexes
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 13;
	localparam int CFG_PAIRS_W = 12;
	localparam int CFG_ROWS_W  = 13;

	localparam logic [CFG_IDX_W-1:0] REG_ROW_PAIRS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS = 2'd1;

	localparam logic [CFG_PAIRS_W-1:0] ROW_PAIRS_RST  = 12'd320;
	localparam logic [CFG_ROWS_W-1:0]  FRAME_ROWS_RST = 13'd480;

	// defaults for the top level parameters
	localparam int DEF_MAX_PAIRS = 2048;
	localparam int DEF_MAX_ROWS  = 4096;
	localparam int DEF_Q_DEPTH   = 4;

	// conversion constants
	localparam int LUMA_OFS   = 16;
	localparam int CHROMA_OFS = 128;
	localparam int K_Y        = 298;
	localparam int K_RV       = 409;
	localparam int K_GU       = 100;
	localparam int K_GV       = 208;
	localparam int K_BU       = 516;
	localparam int ROUND_OFS  = 128;

	// classified pair between front and back
	typedef struct packed {
		logic [7:0] luma_a;
		logic [7:0] luma_b;
		logic [7:0] chroma_u;
		logic [7:0] chroma_v;
		logic       row_end;
		logic       frame_end;
	} pair_item_t;

	// converted pair waiting for the consumer
	typedef struct packed {
		logic [15:0] pixel_a;
		logic [15:0] pixel_b;
		logic        row_end;
		logic        frame_end;
	} pix_item_t;

endpackage

FILE: src/nv2rgb_fifo.sv
module nv2rgb_fifo import nv2rgb_pkg::*; #(
	parameter int WIDTH = 34,
	parameter int DEPTH = DEF_Q_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic [WIDTH-1:0]           wr_data,
	input  logic                       rd_en,
	output logic [WIDTH-1:0]           rd_data,
	output logic                       empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign rd_data = mem_q[rd_ptr_q];
	assign empty   = (count_q == '0);
	assign count   = count_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: src/nv2rgb_front.sv
module nv2rgb_front import nv2rgb_pkg::*; #(
	parameter int MAX_PAIRS = DEF_MAX_PAIRS,
	parameter int MAX_ROWS  = DEF_MAX_ROWS,
	parameter int Q_DEPTH   = DEF_Q_DEPTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         ready,
	input  logic [7:0]                   luma_a,
	input  logic [7:0]                   luma_b,
	input  logic [7:0]                   chroma_u,
	input  logic [7:0]                   chroma_v,
	input  logic [CFG_PAIRS_W-1:0]       row_pairs,
	input  logic [CFG_ROWS_W-1:0]        frame_rows,
	input  logic [$clog2(Q_DEPTH+1)-1:0] q_count,
	output logic                         q_push,
	output pair_item_t                   q_item
);

	localparam int CW    = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
	localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int PL_W  = ($clog2(MAX_PAIRS + 1) > CFG_PAIRS_W) ?
	                       $clog2(MAX_PAIRS + 1) : CFG_PAIRS_W;
	localparam int RL_W  = ($clog2(MAX_ROWS + 1) > CFG_ROWS_W) ?
	                       $clog2(MAX_ROWS + 1) : CFG_ROWS_W;
	localparam int QCW   = $clog2(Q_DEPTH + 1);

	logic [15:0]     line_q [MAX_PAIRS];
	logic [CW-1:0]   pair_col_q;
	logic [RW-1:0]   row_q;

	logic            valid_s1;
	logic [7:0]      luma_a_s1;
	logic [7:0]      luma_b_s1;
	logic [7:0]      chroma_u_s1;
	logic [7:0]      chroma_v_s1;
	logic            odd_s1;
	logic            row_end_s1;
	logic            frame_end_s1;
	logic [15:0]     line_rd_s1;

	logic [PL_W-1:0] pairs_lim;
	logic [RL_W-1:0] rows_lim;
	logic [PL_W-1:0] pairs_ext;
	logic [RL_W-1:0] rows_ext;
	logic [CW-1:0]   col_idx;
	logic            row_end;
	logic            frame_end;
	logic            accept;

	// saturate the limits to 1..max
	assign pairs_ext = PL_W'(row_pairs);
	assign rows_ext  = RL_W'(frame_rows);

	always_comb begin
		if (pairs_ext == '0) begin
			pairs_lim = PL_W'(1);
		end else if (pairs_ext > PL_W'(MAX_PAIRS)) begin
			pairs_lim = PL_W'(MAX_PAIRS);
		end else begin
			pairs_lim = pairs_ext;
		end
		if (rows_ext == '0) begin
			rows_lim = RL_W'(1);
		end else if (rows_ext > RL_W'(MAX_ROWS)) begin
			rows_lim = RL_W'(MAX_ROWS);
		end else begin
			rows_lim = rows_ext;
		end
	end

	// column held inside the row after a shrink of the limit
	assign col_idx   = (PL_W'(pair_col_q) >= pairs_lim) ? CW'(pairs_lim - 1'b1) : pair_col_q;
	assign row_end   = ((PL_W + 1)'(pair_col_q) + 1'b1) >= {1'b0, pairs_lim};
	assign frame_end = row_end && (((RL_W + 1)'(row_q) + 1'b1) >= {1'b0, rows_lim});

	// room for this request and the one already in stage 1
	assign ready  = ((QCW + 1)'(q_count) + (QCW + 1)'(valid_s1)) < (QCW + 1)'(Q_DEPTH);
	assign accept = push && ready;

	// chroma line store: even rows write, odd rows read
	always_ff @(posedge clk) begin
		if (accept && !row_q[0]) begin
			line_q[col_idx] <= {chroma_v, chroma_u};
		end
		if (accept && row_q[0]) begin
			line_rd_s1 <= line_q[col_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			luma_a_s1    <= luma_a;
			luma_b_s1    <= luma_b;
			chroma_u_s1  <= chroma_u;
			chroma_v_s1  <= chroma_v;
			odd_s1       <= row_q[0];
			row_end_s1   <= row_end;
			frame_end_s1 <= frame_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			pair_col_q <= '0;
			row_q      <= '0;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				if (row_end) begin
					pair_col_q <= '0;
					row_q      <= frame_end ? '0 : row_q + 1'b1;
				end else begin
					pair_col_q <= pair_col_q + 1'b1;
				end
			end
		end
	end

	assign q_push             = valid_s1;
	assign q_item.luma_a      = luma_a_s1;
	assign q_item.luma_b      = luma_b_s1;
	assign q_item.chroma_u    = odd_s1 ? line_rd_s1[7:0] : chroma_u_s1;
	assign q_item.chroma_v    = odd_s1 ? line_rd_s1[15:8] : chroma_v_s1;
	assign q_item.row_end     = row_end_s1;
	assign q_item.frame_end   = frame_end_s1;

endmodule

FILE: src/nv2rgb_back.sv
module nv2rgb_back import nv2rgb_pkg::*; #(
	parameter int Q_DEPTH = DEF_Q_DEPTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_empty,
	input  pair_item_t                   in_item,
	output logic                         in_pop,
	input  logic [$clog2(Q_DEPTH+1)-1:0] out_count,
	output logic                         out_push,
	output pix_item_t                    out_item
);

	localparam int QCW = $clog2(Q_DEPTH + 1);

	logic               valid_s1;
	logic signed [17:0] ya_s1;
	logic signed [17:0] yb_s1;
	logic signed [17:0] rv_s1;
	logic signed [17:0] gu_s1;
	logic signed [17:0] gv_s1;
	logic signed [17:0] bu_s1;
	logic               row_end_s1;
	logic               frame_end_s1;

	logic signed [8:0]  c_a;
	logic signed [8:0]  c_b;
	logic signed [8:0]  d_u;
	logic signed [8:0]  e_v;

	function automatic logic [7:0] clamp8(input logic signed [18:0] sum);
		logic [7:0] res;
		if (sum[18]) begin
			res = 8'd0;
		end else if (sum[17:16] != 2'b00) begin
			res = 8'hff;
		end else begin
			res = sum[15:8];
		end
		return res;
	endfunction

	function automatic logic [15:0] pack565(input logic signed [17:0] yk,
	                                        input logic signed [17:0] rv,
	                                        input logic signed [17:0] gu,
	                                        input logic signed [17:0] gv,
	                                        input logic signed [17:0] bu);
		logic signed [18:0] rs;
		logic signed [18:0] gs;
		logic signed [18:0] bs;
		logic [7:0]         r;
		logic [7:0]         g;
		logic [7:0]         b;
		rs = 19'(yk) + 19'(rv) + 19'(ROUND_OFS);
		gs = 19'(yk) - 19'(gu) - 19'(gv) + 19'(ROUND_OFS);
		bs = 19'(yk) + 19'(bu) + 19'(ROUND_OFS);
		r  = clamp8(rs);
		g  = clamp8(gs);
		b  = clamp8(bs);
		return {b[7:3], g[7:2], r[7:3]};
	endfunction

	// pull only when the result queue has room for everything in flight
	assign in_pop = !in_empty &&
	                (((QCW + 1)'(out_count) + (QCW + 1)'(valid_s1)) < (QCW + 1)'(Q_DEPTH));

	assign c_a = $signed({1'b0, in_item.luma_a}) - 9'sd16;
	assign c_b = $signed({1'b0, in_item.luma_b}) - 9'sd16;
	assign d_u = $signed({1'b0, in_item.chroma_u}) - 9'sd128;
	assign e_v = $signed({1'b0, in_item.chroma_v}) - 9'sd128;

	// products by the fixed coefficients
	always_ff @(posedge clk) begin
		if (in_pop) begin
			ya_s1        <= 18'(c_a) * 18'sd298;
			yb_s1        <= 18'(c_b) * 18'sd298;
			rv_s1        <= 18'(e_v) * 18'sd409;
			gu_s1        <= 18'(d_u) * 18'sd100;
			gv_s1        <= 18'(e_v) * 18'sd208;
			bu_s1        <= 18'(d_u) * 18'sd516;
			row_end_s1   <= in_item.row_end;
			frame_end_s1 <= in_item.frame_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_pop;
		end
	end

	// sums, clamp and packing
	assign out_push           = valid_s1;
	assign out_item.pixel_a   = pack565(ya_s1, rv_s1, gu_s1, gv_s1, bu_s1);
	assign out_item.pixel_b   = pack565(yb_s1, rv_s1, gu_s1, gv_s1, bu_s1);
	assign out_item.row_end   = row_end_s1;
	assign out_item.frame_end = frame_end_s1;

endmodule

FILE: src/nv12_to_rgb565_converter_unit.sv
// channel   direction  handshake            payload
// input     in         push / full          luma_a, luma_b, chroma_u, chroma_v
// result    out        empty / pop          pixel_a, pixel_b, row_end, frame_end
// config    in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// one pixel pair per cycle sustained while full stays low; a pair reaches the result ports
// through the line store read, pair queue, product stage and result queue
// arst_n clears the counters, queues and registers to row_pairs 320, frame_rows 480;
// the chroma line store is not cleared, so no clearing pass is needed
// full rises once pair queue and front stage hold Q_DEPTH requests, i.e. the result
// side has backed up; empty falls as soon as a result waits
module nv12_to_rgb565_converter_unit import nv2rgb_pkg::*; #(
	parameter int MAX_PAIRS = DEF_MAX_PAIRS,
	parameter int MAX_ROWS  = DEF_MAX_ROWS,
	parameter int Q_DEPTH   = DEF_Q_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic [7:0]            luma_a,
	input  logic [7:0]            luma_b,
	input  logic [7:0]            chroma_u,
	input  logic [7:0]            chroma_v,
	output logic                  empty,
	input  logic                  pop,
	output logic [15:0]           pixel_a,
	output logic [15:0]           pixel_b,
	output logic                  row_end,
	output logic                  frame_end,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int QCW = $clog2(Q_DEPTH + 1);

	logic [CFG_PAIRS_W-1:0] row_pairs_q;
	logic [CFG_ROWS_W-1:0]  frame_rows_q;

	logic       front_ready;
	logic       pq_push;
	pair_item_t pq_wr_item;
	pair_item_t pq_rd_item;
	logic       pq_pop;
	logic       pq_empty;
	logic [QCW-1:0] pq_count;

	logic       rq_push;
	pix_item_t  rq_wr_item;
	pix_item_t  rq_rd_item;
	logic       rq_pop;
	logic       rq_empty;
	logic [QCW-1:0] rq_count;

	// configuration: always ready, unknown indexes are dropped
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_pairs_q  <= ROW_PAIRS_RST;
			frame_rows_q <= FRAME_ROWS_RST;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_ROW_PAIRS) begin
				row_pairs_q <= cfg_data[CFG_PAIRS_W-1:0];
			end else if (cfg_index == REG_FRAME_ROWS) begin
				frame_rows_q <= cfg_data[CFG_ROWS_W-1:0];
			end
		end
	end

	// front: position tracking and chroma line store
	nv2rgb_front #(
		.MAX_PAIRS (MAX_PAIRS),
		.MAX_ROWS  (MAX_ROWS),
		.Q_DEPTH   (Q_DEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.ready      (front_ready),
		.luma_a     (luma_a),
		.luma_b     (luma_b),
		.chroma_u   (chroma_u),
		.chroma_v   (chroma_v),
		.row_pairs  (row_pairs_q),
		.frame_rows (frame_rows_q),
		.q_count    (pq_count),
		.q_push     (pq_push),
		.q_item     (pq_wr_item)
	);

	assign full = !front_ready;

	// short queue decoupling front and back
	nv2rgb_fifo #(
		.WIDTH ($bits(pair_item_t)),
		.DEPTH (Q_DEPTH)
	) u_pair_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (pq_push),
		.wr_data (pq_wr_item),
		.rd_en   (pq_pop),
		.rd_data (pq_rd_item),
		.empty   (pq_empty),
		.count   (pq_count)
	);

	// back: colour conversion
	nv2rgb_back #(
		.Q_DEPTH (Q_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_empty  (pq_empty),
		.in_item   (pq_rd_item),
		.in_pop    (pq_pop),
		.out_count (rq_count),
		.out_push  (rq_push),
		.out_item  (rq_wr_item)
	);

	// result queue, head shown on the ports
	assign rq_pop = pop && !rq_empty;

	nv2rgb_fifo #(
		.WIDTH ($bits(pix_item_t)),
		.DEPTH (Q_DEPTH)
	) u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (rq_push),
		.wr_data (rq_wr_item),
		.rd_en   (rq_pop),
		.rd_data (rq_rd_item),
		.empty   (rq_empty),
		.count   (rq_count)
	);

	assign empty     = rq_empty;
	assign pixel_a   = rq_rd_item.pixel_a;
	assign pixel_b   = rq_rd_item.pixel_b;
	assign row_end   = rq_rd_item.row_end;
	assign frame_end = rq_rd_item.frame_end;

endmodule

FILE: tb/nv12_to_rgb565_converter_unit_test.sv
`timescale 1ns / 1ps

module nv12_to_rgb565_converter_unit_test;
	import nv2rgb_pkg::*;

	localparam int MAX_PAIRS = DEF_MAX_PAIRS;
	localparam int MAX_ROWS  = DEF_MAX_ROWS;

	// one pixel pair request as the source offers it
	typedef struct packed {
		logic [7:0] luma_a;
		logic [7:0] luma_b;
		logic [7:0] chroma_u;
		logic [7:0] chroma_v;
	} nv_pair_t;

	// directed table: either a pair request or a new frame geometry
	typedef enum logic {STEP_PAIR, STEP_GEOMETRY} step_kind_t;

	typedef struct packed {
		step_kind_t            kind;
		nv_pair_t              pair;
		logic                  typed;
		pix_item_t             want;
		logic [CFG_DATA_W-1:0] pairs_val;
		logic [CFG_DATA_W-1:0] rows_val;
	} plan_row_t;

	logic                  clk;
	logic                  arst_n    = 1'b0;
	logic                  push      = 1'b0;
	logic                  full;
	logic [7:0]            luma_a    = '0;
	logic [7:0]            luma_b    = '0;
	logic [7:0]            chroma_u  = '0;
	logic [7:0]            chroma_v  = '0;
	logic                  empty;
	logic                  pop       = 1'b0;
	logic [15:0]           pixel_a;
	logic [15:0]           pixel_b;
	logic                  row_end;
	logic                  frame_end;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_ROW_PAIRS;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// sideband travelling with the request: a result typed straight into the table
	logic      drv_typed = 1'b0;
	pix_item_t drv_want  = '0;

	// shadow of the frame geometry registers and the block's position in the frame
	logic [CFG_PAIRS_W-1:0] geo_pairs = ROW_PAIRS_RST;
	logic [CFG_ROWS_W-1:0]  geo_rows  = FRAME_ROWS_RST;
	logic [10:0]            col_ptr   = '0;
	logic [11:0]            row_ptr   = '0;
	logic [15:0]            uv_line [MAX_PAIRS];
	bit                     uv_seen [MAX_PAIRS];

	pix_item_t pixels_due [$];

	// bookkeeping
	int mismatches     = 0;
	int pairs_sent     = 0;
	int pairs_taken    = 0;
	int pixels_checked = 0;
	int rows_closed    = 0;
	int frames_closed  = 0;
	int reg_writes     = 0;
	int stalled_cycles = 0;
	int hold_request   = 0;
	bit calm           = 1'b0;

	plan_row_t plan [25];

	nv12_to_rgb565_converter_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.luma_a    (luma_a),
		.luma_b    (luma_b),
		.chroma_u  (chroma_u),
		.chroma_v  (chroma_v),
		.empty     (empty),
		.pop       (pop),
		.pixel_a   (pixel_a),
		.pixel_b   (pixel_b),
		.row_end   (row_end),
		.frame_end (frame_end),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// hard stop in case a handshake never completes
	initial begin
		#(2_000_000);
		$display("FAIL nv12_to_rgb565_converter_unit");
		$finish;
	end

	// ------------------------------------------------------------------
	// bt.601 prediction
	// ------------------------------------------------------------------

	// channel sum to 0..255: negative sums floor to zero, large ones saturate
	function automatic logic [7:0] clamp_channel(input int sum);
		int q;
		if (sum < 0)
			return 8'h00;
		q = sum / 256;
		return (q > 255) ? 8'hff : q[7:0];
	endfunction

	// blue in the top five bits, green in the middle six, red at the bottom
	function automatic logic [15:0] rgb565_of(input logic [7:0] y, u, v);
		int c, d, e;
		logic [7:0] r, g, b;
		c = int'(y) - LUMA_OFS;
		d = int'(u) - CHROMA_OFS;
		e = int'(v) - CHROMA_OFS;
		r = clamp_channel(K_Y * c + K_RV * e + ROUND_OFS);
		g = clamp_channel(K_Y * c - K_GU * d - K_GV * e + ROUND_OFS);
		b = clamp_channel(K_Y * c + K_BU * d + ROUND_OFS);
		return {b[7:3], g[7:2], r[7:3]};
	endfunction

	// row width in force: zero behaves as one, anything past the store is capped
	function automatic int span_of(input logic [CFG_PAIRS_W-1:0] raw);
		if (raw == 0)
			return 1;
		return (raw > MAX_PAIRS) ? MAX_PAIRS : int'(raw);
	endfunction

	// converts one pair and moves the frame position on
	function automatic pix_item_t bt601_pair(input nv_pair_t p);
		int pairs, rows, col;
		logic [7:0] u, v;
		pix_item_t res;
		pairs = span_of(geo_pairs);
		rows  = (geo_rows == 0) ? 1 : ((geo_rows > MAX_ROWS) ? MAX_ROWS : int'(geo_rows));
		// a column left beyond a narrowed row lands on the last column
		col   = (col_ptr >= pairs) ? pairs - 1 : int'(col_ptr);
		if (!row_ptr[0]) begin
			// even row: chroma comes with the request and is kept for the row below
			u = p.chroma_u;
			v = p.chroma_v;
			uv_line[col] = {v, u};
			uv_seen[col] = 1'b1;
		end else begin
			// odd row: chroma fields are ignored, the stored pair is reused
			{v, u} = uv_line[col];
		end
		res.row_end   = (col_ptr + 1 >= pairs);
		res.frame_end = res.row_end && (row_ptr + 1 >= rows);
		res.pixel_a   = rgb565_of(p.luma_a, u, v);
		res.pixel_b   = rgb565_of(p.luma_b, u, v);
		if (res.row_end) begin
			col_ptr = '0;
			row_ptr = res.frame_end ? '0 : row_ptr + 1'b1;
		end else begin
			col_ptr = col_ptr + 1'b1;
		end
		return res;
	endfunction

	// a new row width must never send an odd row to a column that was never
	// filled: on an even row the columns already passed must be written, on an
	// odd row the ones still to come
	function automatic bit width_is_safe(input logic [CFG_PAIRS_W-1:0] raw);
		int p, start, c;
		bit ok;
		p     = span_of(raw);
		start = (col_ptr < p) ? int'(col_ptr) : p - 1;
		ok    = 1'b1;
		if (!row_ptr[0]) begin
			for (c = 0; c < start; c++)
				ok &= uv_seen[c];
		end else begin
			for (c = start; c < p; c++)
				ok &= uv_seen[c];
		end
		return ok;
	endfunction

	// ------------------------------------------------------------------
	// checking
	// ------------------------------------------------------------------

	task automatic flag_mismatch(input string what, input logic [15:0] got, want);
		mismatches++;
		$display("mismatch on result %0d: %s is %h, expected %h",
			pixels_checked, what, got, want);
	endtask

	// results are checked before new requests are predicted, so a result can
	// never be matched against a request taken on the same edge
	always @(posedge clk) begin : scoreboard
		pix_item_t due, fresh;
		if (pop && !empty) begin
			if (pixels_due.size() == 0) begin
				flag_mismatch("result with nothing pending, pixel_a", pixel_a, 16'h0000);
			end else begin
				due = pixels_due.pop_front();
				if (pixel_a !== due.pixel_a)
					flag_mismatch("pixel_a", pixel_a, due.pixel_a);
				if (pixel_b !== due.pixel_b)
					flag_mismatch("pixel_b", pixel_b, due.pixel_b);
				if (row_end !== due.row_end)
					flag_mismatch("row_end", {15'd0, row_end}, {15'd0, due.row_end});
				if (frame_end !== due.frame_end)
					flag_mismatch("frame_end", {15'd0, frame_end}, {15'd0, due.frame_end});
			end
			pixels_checked++;
		end
		if (push && full)
			stalled_cycles++;
		if (push && !full) begin
			fresh = bt601_pair({luma_a, luma_b, chroma_u, chroma_v});
			if (drv_typed)
				fresh = drv_want;
			rows_closed   += fresh.row_end;
			frames_closed += fresh.frame_end;
			pixels_due.push_back(fresh);
			pairs_taken++;
		end
	end

	// ------------------------------------------------------------------
	// driving
	// ------------------------------------------------------------------

	// idle cycles before the next request or pop; none at all in a calm phase
	function automatic int pace();
		return calm ? 0 : $urandom_range(0, 9);
	endfunction

	// extremes and the neutral points turn up often, the rest is uniform
	function automatic logic [7:0] pick_sample();
		unique case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hff;
			2: return 8'd16;
			3: return 8'd128;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic nv_pair_t random_pair();
		nv_pair_t p;
		p.luma_a   = pick_sample();
		p.luma_b   = pick_sample();
		p.chroma_u = pick_sample();
		p.chroma_v = pick_sample();
		return p;
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_pairs();
		unique case ($urandom_range(0, 9))
			0: return '0;
			1: return 13'd1;
			7: return 13'($urandom_range(9, 40));
			// bit 12 lies outside the register and must be dropped
			8: return 13'h1000 | 13'($urandom_range(1, 6));
			9: return 13'($urandom_range(2049, 4095));
			default: return 13'($urandom_range(2, 8));
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_rows();
		unique case ($urandom_range(0, 9))
			0: return '0;
			1: return 13'd1;
			7: return 13'($urandom_range(7, 20));
			8: return 13'($urandom_range(4097, 8191));
			9: return 13'd4096;
			default: return 13'($urandom_range(2, 6));
		endcase
	endfunction

	// offers one request and returns on the edge that takes it; push stays up
	// when the next request follows without a gap
	task automatic offer_pair(input nv_pair_t p, input logic typed, input pix_item_t want);
		int gap;
		gap = pace();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push      <= 1'b1;
		luma_a    <= p.luma_a;
		luma_b    <= p.luma_b;
		chroma_u  <= p.chroma_u;
		chroma_v  <= p.chroma_v;
		drv_typed <= typed;
		drv_want  <= want;
		@(posedge clk);
		while (full)
			@(posedge clk);
		pairs_sent++;
	endtask

	// sender pauses until every pending result has come back
	task automatic wait_drained();
		push <= 1'b0;
		while (pixels_checked < pairs_sent)
			@(posedge clk);
	endtask

	// only called with the block idle; the row width is held back when it would
	// expose unwritten chroma, the height is always written
	task automatic load_geometry(input logic [CFG_DATA_W-1:0] pairs_val, rows_val,
			input bit with_pairs);
		if (with_pairs) begin
			cfg_valid <= 1'b1;
			cfg_index <= REG_ROW_PAIRS;
			cfg_data  <= pairs_val;
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
			geo_pairs = pairs_val[CFG_PAIRS_W-1:0];
			reg_writes++;
		end
		cfg_valid <= 1'b1;
		cfg_index <= REG_FRAME_ROWS;
		cfg_data  <= rows_val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		geo_rows = rows_val[CFG_ROWS_W-1:0];
		reg_writes++;
		cfg_valid <= 1'b0;
	endtask

	// directed table rows
	function automatic plan_row_t pair_step(input logic [7:0] ya, yb, u, v);
		plan_row_t r;
		r      = '0;
		r.kind = STEP_PAIR;
		r.pair = {ya, yb, u, v};
		return r;
	endfunction

	function automatic plan_row_t known_step(input logic [7:0] ya, yb, u, v,
			input logic [15:0] pa, pb, input logic re, fe);
		plan_row_t r;
		r       = pair_step(ya, yb, u, v);
		r.typed = 1'b1;
		r.want  = {pa, pb, re, fe};
		return r;
	endfunction

	function automatic plan_row_t geometry_step(input logic [CFG_DATA_W-1:0] p, rws);
		plan_row_t r;
		r           = '0;
		r.kind      = STEP_GEOMETRY;
		r.pairs_val = p;
		r.rows_val  = rws;
		return r;
	endfunction

	// receiver: random stalls per result, plus one long hold-off on request
	initial begin : drain
		int gap;
		wait (arst_n);
		@(posedge clk);
		forever begin
			gap = pace() + hold_request;
			hold_request = 0;
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
			while (empty)
				@(posedge clk);
		end
	end

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------

	initial begin : stimulus
		int i, phase, batch, random_sent;
		logic [CFG_DATA_W-1:0] cand;

		// reset geometry 320 x 480, first row even
		plan[0]  = known_step(8'd16, 8'd16, 8'd128, 8'd128, 16'h0000, 16'h0000, 1'b0, 1'b0);
		plan[1]  = known_step(8'd255, 8'd255, 8'd128, 8'd128, 16'hffff, 16'hffff, 1'b0, 1'b0);
		plan[2]  = pair_step(8'd0, 8'd0, 8'd0, 8'd0);
		plan[3]  = pair_step(8'd255, 8'd255, 8'd255, 8'd255);
		plan[4]  = pair_step(8'd0, 8'd255, 8'd255, 8'd0);
		plan[5]  = pair_step(8'd255, 8'd0, 8'd0, 8'd255);
		plan[6]  = pair_step(8'd128, 8'd64, 8'd90, 8'd240);
		// narrow to three pairs with a stray bit 12, while the column is already
		// past the new width; three rows, so the last row is even
		plan[7]  = geometry_step(13'h1003, 13'd3);
		plan[8]  = pair_step(8'd200, 8'd30, 8'd10, 8'd250);
		// odd row: chroma fields are noise and must be ignored
		plan[9]  = pair_step(8'd80, 8'd180, 8'd255, 8'd255);
		plan[10] = pair_step(8'd235, 8'd16, 8'd0, 8'd0);
		plan[11] = pair_step(8'd50, 8'd120, 8'd128, 8'd128);
		plan[12] = pair_step(8'd17, 8'd254, 8'd1, 8'd254);
		plan[13] = pair_step(8'd100, 8'd100, 8'd200, 8'd60);
		plan[14] = pair_step(8'd150, 8'd90, 8'd30, 8'd220);
		plan[15] = pair_step(8'd60, 8'd70, 8'd255, 8'd0);
		// zero in both registers acts as one: every pair closes row and frame
		plan[16] = geometry_step(13'd0, 13'd0);
		plan[17] = known_step(8'd16, 8'd16, 8'd128, 8'd128, 16'h0000, 16'h0000, 1'b1, 1'b1);
		plan[18] = known_step(8'd255, 8'd255, 8'd128, 8'd128, 16'hffff, 16'hffff, 1'b1, 1'b1);
		// tallest frame, height written out of range
		plan[19] = geometry_step(13'd1, 13'h1fff);
		plan[20] = pair_step(8'd33, 8'd44, 8'd55, 8'd66);
		plan[21] = pair_step(8'd200, 8'd100, 8'd0, 8'd255);
		// row counter beyond a shortened frame closes it on the next row end
		plan[22] = geometry_step(13'd2, 13'd2);
		plan[23] = pair_step(8'd90, 8'd10, 8'd240, 8'd16);
		plan[24] = pair_step(8'd0, 8'd255, 8'd128, 8'd0);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (i = 0; i < 25; i++) begin
			if (plan[i].kind == STEP_GEOMETRY) begin
				wait_drained();
				load_geometry(plan[i].pairs_val, plan[i].rows_val, 1'b1);
			end else begin
				offer_pair(plan[i].pair, plan[i].typed, plan[i].want);
			end
		end

		// random phases, each starting from an idle block
		phase       = 0;
		random_sent = 0;
		while (random_sent < 600) begin
			wait_drained();
			if (phase == 2) begin
				// receiver holds off while requests keep coming: the block fills
				// and full must push back
				hold_request = 60;
				calm         = 1'b1;
				batch        = 30;
			end else begin
				calm  = ($urandom_range(0, 4) == 0);
				batch = $urandom_range(8, 50);
			end
			if (phase == 0 || $urandom_range(0, 2) != 0) begin
				cand = pick_pairs();
				load_geometry(cand, pick_rows(), width_is_safe(cand[CFG_PAIRS_W-1:0]));
			end
			repeat (batch)
				offer_pair(random_pair(), 1'b0, '0);
			random_sent += batch;
			phase++;
		end
		calm = 1'b0;

		// let everything come back, then keep watching for anything spurious
		wait_drained();
		repeat (8) @(posedge clk);

		$display("ran %0d pixel pairs over %0d rows and %0d frames with %0d register writes",
			pairs_taken, rows_closed, frames_closed, reg_writes);
		$display("%0d results checked, input held back by full on %0d cycles",
			pixels_checked, stalled_cycles);
		if (mismatches == 0 && pixels_due.size() == 0)
			$display("PASS nv12_to_rgb565_converter_unit");
		else
			$display("FAIL nv12_to_rgb565_converter_unit");
		$finish;
	end

endmodule

FILE: nv12_to_rgb565_converter_unit.f
src/nv2rgb_pkg.sv
src/nv2rgb_fifo.sv
src/nv2rgb_front.sv
src/nv2rgb_back.sv
src/nv12_to_rgb565_converter_unit.sv
tb/nv12_to_rgb565_converter_unit_test.sv
